// ===== rtl/core/sdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial download deframer package
// Shared widths, byte codes, result kinds, payload types and the CRC-16 step.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 32;
  localparam int CRC_W           = 16;
  localparam int KIND_W          = 3;
  localparam int DEF_ADDR_WIDTH  = 32;

  // Special bytes on the serial line.
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1b;
  localparam logic [BYTE_W-1:0] ABORT_BYTE = 8'h03;
  localparam logic [BYTE_W-1:0] START_MARK = 8'h3a;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0a;

  // CCITT generator without its top bit.
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_CONSUMED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_CRC  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT    = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] load_address;
  } cfg_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic [WORD_W-1:0] frame_length;
    logic [CRC_W-1:0]  computed_crc;
    logic [CRC_W-1:0]  received_crc;
  } out_item_t;

  // Shift one byte, MSB first, into an augmented CRC-16.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = crc_in;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb  = crc[CRC_W-1];
      crc = {crc[CRC_W-2:0], data[i]} ^ (fb ? CRC_POLY : '0);
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sdd_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface sdd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sdd_frame_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer sequencing core
// Holds the frame state and works out the result for one byte combinationally.
// ----------------------------------------------------------------------------
module sdd_frame_core #(
  parameter int ADDR_WIDTH = sdd_pkg::DEF_ADDR_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [sdd_pkg::BYTE_W-1:0]          rx_byte,
  input  logic [sdd_pkg::WORD_W-1:0]          load_address,
  output sdd_pkg::out_item_t                  res
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CRC  = 3'd3;
  localparam logic [2:0] PH_EOL  = 3'd4;

  logic [2:0]                     phase_r, phase_nxt;
  logic                           esc_r, esc_nxt;
  logic [1:0]                     idx_r, idx_nxt;
  logic [sdd_pkg::WORD_W-1:0]     len_r, len_nxt;
  logic [sdd_pkg::WORD_W-1:0]     left_r, left_nxt;
  logic [ADDR_WIDTH-1:0]          ptr_r, ptr_nxt;
  logic [sdd_pkg::CRC_W-1:0]      crc_r, crc_nxt;
  logic [sdd_pkg::CRC_W-1:0]      trl_r, trl_nxt;

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    crc_nxt   = crc_r;
    trl_nxt   = trl_r;
    res       = '0;
    res.kind  = sdd_pkg::KIND_CONSUMED;

    if (phase_r inside {PH_LEN, PH_DATA, PH_CRC}) begin
      if (!esc_r && rx_byte == sdd_pkg::ABORT_BYTE) begin
        phase_nxt = PH_HUNT;
        esc_nxt   = 1'b0;
        idx_nxt   = 2'd0;
        res.kind  = sdd_pkg::KIND_ABORT;
      end else if (!esc_r && rx_byte == sdd_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        case (phase_r)
          PH_LEN: begin
            len_nxt = len_r | ({24'd0, rx_byte} << {idx_r, 3'b000});
            if (idx_r == 2'd3) begin
              idx_nxt   = 2'd0;
              left_nxt  = len_nxt;
              crc_nxt   = '0;
              phase_nxt = (len_nxt == '0) ? PH_CRC : PH_DATA;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_DATA: begin
            res.kind          = sdd_pkg::KIND_WRITE;
            res.write_address = sdd_pkg::WORD_W'(ptr_r);
            res.write_data    = rx_byte;
            ptr_nxt           = ptr_r + ADDR_WIDTH'(1);
            crc_nxt           = sdd_pkg::crc16_byte(crc_r, rx_byte);
            left_nxt          = left_r - 32'd1;
            if (left_r == 32'd1) begin
              idx_nxt   = 2'd0;
              phase_nxt = PH_CRC;
            end
          end
          default: begin
            trl_nxt = trl_r | ({8'd0, rx_byte} << {idx_r[0], 3'b000});
            if (idx_r != 2'd0) begin
              idx_nxt   = 2'd0;
              phase_nxt = PH_EOL;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        endcase
      end
    end else if (phase_r == PH_EOL) begin
      if (rx_byte == sdd_pkg::ABORT_BYTE) begin
        phase_nxt = PH_HUNT;
        esc_nxt   = 1'b0;
        idx_nxt   = 2'd0;
        res.kind  = sdd_pkg::KIND_ABORT;
      end else if (rx_byte == sdd_pkg::CR_BYTE || rx_byte == sdd_pkg::LF_BYTE) begin
        res.kind         = (crc_r == trl_r) ? sdd_pkg::KIND_OK : sdd_pkg::KIND_BAD_CRC;
        res.frame_length = len_r;
        res.computed_crc = crc_r;
        res.received_crc = trl_r;
        phase_nxt        = PH_HUNT;
        esc_nxt          = 1'b0;
        idx_nxt          = 2'd0;
      end
    end else begin
      // Hunting; unused phase codes fall in here as well.
      if (rx_byte == sdd_pkg::ABORT_BYTE) begin
        phase_nxt = PH_HUNT;
        esc_nxt   = 1'b0;
        idx_nxt   = 2'd0;
        res.kind  = sdd_pkg::KIND_ABORT;
      end else if (rx_byte == sdd_pkg::START_MARK) begin
        phase_nxt = PH_LEN;
        esc_nxt   = 1'b0;
        idx_nxt   = 2'd0;
        len_nxt   = '0;
        left_nxt  = '0;
        crc_nxt   = '0;
        trl_nxt   = '0;
        ptr_nxt   = ADDR_WIDTH'(load_address);
      end else begin
        phase_nxt = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      esc_r   <= 1'b0;
      idx_r   <= 2'd0;
      len_r   <= '0;
      left_r  <= '0;
      ptr_r   <= '0;
      crc_r   <= '0;
      trl_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      ptr_r   <= ptr_nxt;
      crc_r   <= crc_nxt;
      trl_r   <= trl_nxt;
    end
  end

  a_esc_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r == PH_LEN || phase_r == PH_DATA || phase_r == PH_CRC))
    else $error("escape pending outside the length, data or trailer fields");

  a_start_enters_len : assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_HUNT) && (rx_byte == sdd_pkg::START_MARK)
    |=> phase_r == PH_LEN)
    else $error("start mark did not open a frame");

  a_ptr_advances : assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.kind == sdd_pkg::KIND_WRITE)
    |=> ptr_r == ADDR_WIDTH'($past(ptr_r) + ADDR_WIDTH'(1)))
    else $error("write pointer did not advance after a data write");

endmodule
`default_nettype wire

// ===== rtl/core/sdd_result_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output register with skid slot, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module sdd_result_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sdd_pkg::out_item_t push_item,
  output logic               space,
  sdd_chan_if.source         out_ch
);

  logic [1:0]         cnt_r, cnt_nxt;
  sdd_pkg::out_item_t head_r, head_nxt;
  sdd_pkg::out_item_t skid_r, skid_nxt;
  logic               pop;

  assign pop            = out_ch.valid && out_ch.ready;
  assign space          = (cnt_r != 2'd2);
  assign out_ch.valid   = (cnt_r != 2'd0);
  assign out_ch.payload = head_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_item;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_item;
        end else if (push) begin
          skid_nxt = push_item;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("result pushed into a full buffer");

endmodule
`default_nettype wire

// ===== rtl/core/serial_download_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial download deframer
// Receives framed, byte-stuffed downloads and turns them into memory writes.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                         Item
//  -------  ---  ----------------------------------------------  ----------------------
//  in_ch    in   rx_byte[7:0]                                    one received byte
//  out_ch   out  kind, write_address, write_data, frame_length,  one result per byte
//                computed_crc, received_crc
//  cfg_ch   in   load_address[31:0]                              load base register
//
//  One item is taken every clock cycle when the output side keeps up; each
//  result passes through the input register, then the result buffer. The frame
//  state and CRC update once per byte.
//  Reset is synchronous and active low; it returns the block to hunting for
//  the start mark and clears the load base to zero.
//  A stalled output holds up to two results before in_ch.ready drops.
//  cfg_ch is always ready.
//
// A frame is ':' then a four-byte length (least significant byte first), the
// data bytes and a two-byte CRC trailer, closed by CR or LF. ESC quotes the
// next byte inside the length, data and trailer, and an unquoted 0x03 aborts
// the frame wherever it appears. Every byte yields exactly one result item.
// ----------------------------------------------------------------------------
module serial_download_deframer #(
  parameter int ADDR_WIDTH = sdd_pkg::DEF_ADDR_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  sdd_chan_if.sink   in_ch,
  sdd_chan_if.source out_ch,
  sdd_chan_if.sink   cfg_ch
);

  // Load base, to be written by the user only while the block is idle; the block does not enforce this.
  logic [sdd_pkg::WORD_W-1:0] load_addr_r;

  // Input register: one byte waiting to be processed.
  logic                       in_valid_r, in_valid_nxt;
  logic [sdd_pkg::BYTE_W-1:0] in_byte_r;

  logic                       space;
  logic                       advance;
  logic                       in_fire;
  sdd_pkg::out_item_t         core_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
    end else if (cfg_ch.valid) begin
      load_addr_r <= cfg_ch.payload.load_address;
    end
  end

  // The byte moves on whenever the result buffer has a free slot, so the
  // input side is decoupled from the output side by the registered count.
  assign advance     = in_valid_r && space;
  assign in_ch.ready = !in_valid_r || space;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.payload.rx_byte;
    end
  end

  sdd_frame_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .rx_byte      (in_byte_r),
    .load_address (load_addr_r),
    .res          (core_res)
  );

  sdd_result_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_item (core_res),
    .space     (space),
    .out_ch    (out_ch)
  );

  a_hold_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !space |=> in_valid_r && $stable(in_byte_r))
    else $error("buffered byte lost while the result buffer was full");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("input not ready with an empty input register");

endmodule
`default_nettype wire

// ===== dv/tb_serial_download_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial download deframer testbench
// Feeds framed, byte-stuffed downloads, noise and broken frames, predicts
// every result item in step with the accepted bytes and checks each field.
// ----------------------------------------------------------------------------
module tb_serial_download_deframer;

  // Phases of the frame parser, kept here for the predictor alone.
  localparam logic [2:0] HUNTING    = 3'd0;
  localparam logic [2:0] LEN_FIELD  = 3'd1;
  localparam logic [2:0] DATA_FIELD = 3'd2;
  localparam logic [2:0] CRC_FIELD  = 3'd3;
  localparam logic [2:0] LINE_END   = 3'd4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sdd_chan_if #(.payload_t(sdd_pkg::in_item_t))  in_ch ();
  sdd_chan_if #(.payload_t(sdd_pkg::out_item_t)) out_ch ();
  sdd_chan_if #(.payload_t(sdd_pkg::cfg_item_t)) cfg_ch ();

  serial_download_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes still to be offered, and the results that the accepted bytes call for.
  logic [sdd_pkg::BYTE_W-1:0] rx_bytes_q[$];
  sdd_pkg::out_item_t         byte_results_q[$];
  logic [sdd_pkg::BYTE_W-1:0] frame_q[$];
  int unsigned                items_queued = 0;
  int unsigned                fail_count   = 0;
  bit                         calm         = 1'b0;
  logic [sdd_pkg::WORD_W-1:0] phase_base[5];

  // Shadow of the parser state, updated once per accepted byte.
  logic [2:0]                 ph        = HUNTING;
  logic                       esc_seen  = 1'b0;
  logic [1:0]                 fld_idx   = 2'd0;
  logic [sdd_pkg::WORD_W-1:0] frame_len = '0;
  logic [sdd_pkg::WORD_W-1:0] remaining = '0;
  logic [sdd_pkg::WORD_W-1:0] wr_ptr    = '0;
  logic [sdd_pkg::WORD_W-1:0] base_addr = '0;
  logic [sdd_pkg::CRC_W-1:0]  data_crc  = '0;
  logic [sdd_pkg::CRC_W-1:0]  trail_crc = '0;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // One byte through the CCITT shift register, message bits MSB first, with
  // the generator's top bit kept in the seventeenth stage.
  function automatic logic [sdd_pkg::CRC_W-1:0] crc_step(
      input logic [sdd_pkg::CRC_W-1:0]  crc,
      input logic [sdd_pkg::BYTE_W-1:0] b);
    logic [sdd_pkg::CRC_W:0] acc;
    acc = {1'b0, crc};
    for (int k = sdd_pkg::BYTE_W - 1; k >= 0; k--) begin
      acc = {acc[sdd_pkg::CRC_W-1:0], b[k]};
      if (acc[sdd_pkg::CRC_W]) acc = acc ^ {1'b1, sdd_pkg::CRC_POLY};
    end
    return acc[sdd_pkg::CRC_W-1:0];
  endfunction

  // Advances the shadow parser by one received byte and returns the result
  // item that the byte must produce.
  function automatic sdd_pkg::out_item_t deframe_byte(input logic [sdd_pkg::BYTE_W-1:0] b);
    sdd_pkg::out_item_t r;
    r      = '0;
    r.kind = sdd_pkg::KIND_CONSUMED;
    case (ph)
      LEN_FIELD, DATA_FIELD, CRC_FIELD: begin
        if (!esc_seen && b == sdd_pkg::ABORT_BYTE) begin
          // An unquoted abort byte drops the frame wherever it stands.
          ph       = HUNTING;
          esc_seen = 1'b0;
          fld_idx  = 2'd0;
          r.kind   = sdd_pkg::KIND_ABORT;
        end else if (!esc_seen && b == sdd_pkg::ESC_BYTE) begin
          esc_seen = 1'b1;
        end else begin
          esc_seen = 1'b0;
          if (ph == LEN_FIELD) begin
            frame_len = frame_len | (sdd_pkg::WORD_W'(b) << (8 * fld_idx));
            if (fld_idx == 2'd3) begin
              fld_idx   = 2'd0;
              remaining = frame_len;
              data_crc  = '0;
              // With no data the trailer follows at once.
              ph = (frame_len == '0) ? CRC_FIELD : DATA_FIELD;
            end else begin
              fld_idx++;
            end
          end else if (ph == DATA_FIELD) begin
            r.kind          = sdd_pkg::KIND_WRITE;
            r.write_address = wr_ptr;
            r.write_data    = b;
            wr_ptr          = wr_ptr + 32'd1;
            data_crc        = crc_step(data_crc, b);
            remaining       = remaining - 32'd1;
            if (remaining == '0) begin
              fld_idx = 2'd0;
              ph      = CRC_FIELD;
            end
          end else begin
            trail_crc = trail_crc | (sdd_pkg::CRC_W'(b) << (8 * fld_idx[0]));
            if (fld_idx != 2'd0) begin
              fld_idx = 2'd0;
              ph      = LINE_END;
            end else begin
              fld_idx++;
            end
          end
        end
      end
      LINE_END: begin
        if (b == sdd_pkg::ABORT_BYTE) begin
          ph       = HUNTING;
          esc_seen = 1'b0;
          fld_idx  = 2'd0;
          r.kind   = sdd_pkg::KIND_ABORT;
        end else if (b == sdd_pkg::CR_BYTE || b == sdd_pkg::LF_BYTE) begin
          r.kind         = (data_crc == trail_crc) ? sdd_pkg::KIND_OK
                                                   : sdd_pkg::KIND_BAD_CRC;
          r.frame_length = frame_len;
          r.computed_crc = data_crc;
          r.received_crc = trail_crc;
          ph       = HUNTING;
          esc_seen = 1'b0;
          fld_idx  = 2'd0;
        end
      end
      default: begin
        // Hunting; any unused phase code behaves the same way.
        if (b == sdd_pkg::ABORT_BYTE) begin
          ph       = HUNTING;
          esc_seen = 1'b0;
          fld_idx  = 2'd0;
          r.kind   = sdd_pkg::KIND_ABORT;
        end else if (b == sdd_pkg::START_MARK) begin
          ph        = LEN_FIELD;
          esc_seen  = 1'b0;
          fld_idx   = 2'd0;
          frame_len = '0;
          remaining = '0;
          data_crc  = '0;
          trail_crc = '0;
          // The load base is latched here, so a later register write only
          // moves the next frame.
          wr_ptr = base_addr;
        end else begin
          ph = HUNTING;
        end
      end
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers the queued bytes, idling at random unless the run is calm.
  // The expected result is worked out at the edge that accepts the byte.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        byte_results_q.push_back(deframe_byte(in_ch.payload.rx_byte));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_bytes_q.size() == 0 || (!calm && $urandom_range(0, 99) < 30)) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid           <= 1'b1;
          in_ch.payload.rx_byte <= rx_bytes_q.pop_front();
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: every accepted result is checked against the oldest prediction.
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [sdd_pkg::WORD_W-1:0] want,
                             input logic [sdd_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    sdd_pkg::out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (byte_results_q.size() == 0) begin
          $error("result item 0x%0h arrived with none outstanding", out_ch.payload);
          fail_count++;
        end else begin
          want = byte_results_q.pop_front();
          check_field("kind",          want.kind,          out_ch.payload.kind);
          check_field("write_address", want.write_address, out_ch.payload.write_address);
          check_field("write_data",    want.write_data,    out_ch.payload.write_data);
          check_field("frame_length",  want.frame_length,  out_ch.payload.frame_length);
          check_field("computed_crc",  want.computed_crc,  out_ch.payload.computed_crc);
          check_field("received_crc",  want.received_crc,  out_ch.payload.received_crc);
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  task automatic send_byte(input logic [sdd_pkg::BYTE_W-1:0] b);
    rx_bytes_q.push_back(b);
    items_queued++;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k]);
  endtask

  // Appends a byte that belongs to the length, data or trailer, quoting it
  // where it would otherwise be taken as a control byte, and now and then
  // quoting an ordinary byte as well.
  task automatic add_stuffed(input logic [sdd_pkg::BYTE_W-1:0] b, input int esc_pct);
    if (b == sdd_pkg::ESC_BYTE || b == sdd_pkg::ABORT_BYTE ||
        $urandom_range(0, 99) < esc_pct)
      frame_q.push_back(sdd_pkg::ESC_BYTE);
    frame_q.push_back(b);
  endtask

  // Random byte that differs from the three given.
  function automatic logic [sdd_pkg::BYTE_W-1:0] pick_other(
      input logic [sdd_pkg::BYTE_W-1:0] a,
      input logic [sdd_pkg::BYTE_W-1:0] b,
      input logic [sdd_pkg::BYTE_W-1:0] c);
    logic [sdd_pkg::BYTE_W-1:0] d;
    do d = sdd_pkg::BYTE_W'($urandom); while (d == a || d == b || d == c);
    return d;
  endfunction

  // Builds a frame without its line end in frame_q. A negative fill gives
  // random data; a bad trailer CRC is flipped in some random bits.
  task automatic make_frame(input int n, input bit bad_crc, input int fill,
                            input int esc_pct);
    logic [sdd_pkg::WORD_W-1:0] len;
    logic [sdd_pkg::CRC_W-1:0]  crc;
    logic [sdd_pkg::BYTE_W-1:0] d;
    len = sdd_pkg::WORD_W'(n);
    crc = '0;
    frame_q.delete();
    frame_q.push_back(sdd_pkg::START_MARK);
    for (int k = 0; k < 4; k++) add_stuffed(len[8*k +: 8], esc_pct);
    for (int k = 0; k < n; k++) begin
      d   = (fill < 0) ? sdd_pkg::BYTE_W'($urandom) : sdd_pkg::BYTE_W'(fill);
      crc = crc_step(crc, d);
      add_stuffed(d, esc_pct);
    end
    if (bad_crc) crc = crc ^ sdd_pkg::CRC_W'($urandom_range(1, 16'hffff));
    add_stuffed(crc[7:0], esc_pct);
    add_stuffed(crc[15:8], esc_pct);
  endtask

  // Waits until no byte is pending and every result has been seen. Sampling
  // on the falling edge keeps clear of the updates made at the rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_ch.valid || byte_results_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_load_address(input logic [sdd_pkg::WORD_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid                <= 1'b1;
    cfg_ch.payload.load_address <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    base_addr     = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned start;
    int          sel;
    int          cut;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part, with the load base at its top so the write address sits
    // at the very end of the address space.
    write_load_address(32'hffff_ffff);
    // Noise at both ends of the byte range, then an abort while hunting.
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(sdd_pkg::ABORT_BYTE);
    // A one-byte frame whose data byte is a quoted abort, with a broken CRC.
    make_frame(1, 1'b1, sdd_pkg::ABORT_BYTE, 0);
    frame_q.push_back(sdd_pkg::CR_BYTE);
    send_frame();
    // Zero length: straight to the trailer, with noise before the line end.
    make_frame(0, 1'b0, -1, 0);
    frame_q.push_back(8'h41);
    frame_q.push_back(sdd_pkg::LF_BYTE);
    send_frame();
    // Abort in the length field.
    send_byte(sdd_pkg::START_MARK);
    send_byte(sdd_pkg::ABORT_BYTE);

    // Random part: several load bases, the extremes and a wrap among them.
    phase_base[0] = 32'hffff_fffc;
    phase_base[1] = 32'h0000_0000;
    phase_base[2] = $urandom;
    phase_base[3] = 32'h8000_0000;
    phase_base[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      // The pause here also lets every outstanding result drain.
      wait_idle();
      write_load_address(phase_base[p]);
      // One phase runs without any idling on either side.
      calm  = (p == 2);
      start = items_queued;
      while (items_queued - start < 130) begin
        sel = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2))
          send_byte(pick_other(sdd_pkg::START_MARK, sdd_pkg::ABORT_BYTE,
                               sdd_pkg::ABORT_BYTE));
        if (sel < 70) begin
          // Well-formed frame with random content.
          make_frame(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10),
                     $urandom_range(0, 99) < 15, -1, 10);
          repeat ($urandom_range(0, 1))
            frame_q.push_back(pick_other(sdd_pkg::CR_BYTE, sdd_pkg::LF_BYTE,
                                         sdd_pkg::ABORT_BYTE));
          frame_q.push_back($urandom_range(0, 1) ? sdd_pkg::CR_BYTE : sdd_pkg::LF_BYTE);
          send_frame();
        end else if (sel < 85) begin
          // Frame cut short at a random point and aborted. Two abort bytes
          // make sure the frame ends even when the cut follows an ESC.
          make_frame($urandom_range(0, 8), 1'b0, -1, 10);
          frame_q.push_back(sdd_pkg::CR_BYTE);
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
          frame_q.push_back(sdd_pkg::ABORT_BYTE);
          frame_q.push_back(sdd_pkg::ABORT_BYTE);
          send_frame();
        end else if (sel < 90) begin
          // Huge length, abandoned part way through the data.
          frame_q.delete();
          frame_q.push_back(sdd_pkg::START_MARK);
          repeat (3) add_stuffed(sdd_pkg::BYTE_W'($urandom), 10);
          add_stuffed(sdd_pkg::BYTE_W'($urandom_range(1, 255)), 10);
          repeat ($urandom_range(1, 5)) add_stuffed(sdd_pkg::BYTE_W'($urandom), 10);
          frame_q.push_back(sdd_pkg::ABORT_BYTE);
          frame_q.push_back(sdd_pkg::ABORT_BYTE);
          send_frame();
        end else begin
          // Raw line noise, sometimes closed by an abort.
          repeat ($urandom_range(1, 4)) send_byte(sdd_pkg::BYTE_W'($urandom));
          if ($urandom_range(0, 1)) send_byte(sdd_pkg::ABORT_BYTE);
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_download_deframer verification clean");
    end else begin
      $display("serial_download_deframer verification failed");
    end
    $finish;
  end

  // Guard against a hang; a correct run needs a small fraction of this.
  initial begin
    #2_000_000;
    $display("serial_download_deframer verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sdd_pkg.sv
rtl/core/sdd_chan_if.sv
rtl/core/sdd_frame_core.sv
rtl/core/sdd_result_buf.sv
rtl/core/serial_download_deframer.sv
dv/tb_serial_download_deframer.sv
